>>> rtl/lgs_pkg.sv
package lgs_pkg;

  // Default grid bounds and register reset values.
  localparam int unsigned MaxRowsDef   = 32;
  localparam int unsigned MaxColsDef   = 64;
  localparam int unsigned RowsResetVal = 30;
  localparam int unsigned ColsResetVal = 50;
  localparam int unsigned MinDim       = 2;

  // Window columns kept in registers; the newest column comes straight from the
  // line buffers, so two registered columns complete the 3x3 window.
  localparam int unsigned WinCols = 2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgActiveRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgActiveCols = 2'd1;

  // One window column: bit k is window row k (0 oldest row, 2 newest row).
  typedef logic [2:0] col_bits_t;

  function automatic logic [3:0] ones3(col_bits_t v);
    return 4'(v[0]) + 4'(v[1]) + 4'(v[2]);
  endfunction

  // B3/S23 rule on three window columns. With ctr_mid set the center cell
  // sits in window row 1 and all three rows count; otherwise it sits in
  // row 2 and row 0 lies outside the neighborhood.
  function automatic logic life_rule(col_bits_t left, col_bits_t mid, col_bits_t right,
                                     logic ctr_mid);
    col_bits_t  span;
    col_bits_t  cbit;
    logic [3:0] n;
    logic       alive;
    span  = ctr_mid ? 3'b111 : 3'b110;
    cbit  = ctr_mid ? 3'b010 : 3'b100;
    n     = ones3(left & span) + ones3(mid & span & ~cbit) + ones3(right & span);
    alive = ctr_mid ? mid[1] : mid[2];
    return (n == 4'd3) || (alive && (n == 4'd2));
  endfunction

endpackage

>>> rtl/lgs_if.sv
interface lgs_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

interface lgs_result_if #(
  parameter int unsigned RowW = 5,
  parameter int unsigned ColW = 6
);
  logic            valid;
  logic            ready;
  logic [RowW-1:0] out_row;
  logic [ColW-1:0] out_col;
  logic            next_alive;
  logic            gen_done;

  modport source (output valid, output out_row, output out_col, output next_alive,
                  output gen_done, input ready);
  modport sink (input valid, input out_row, input out_col, input next_alive,
                input gen_done, output ready);
endinterface

interface lgs_cfg_if #(
  parameter int unsigned DataW = 7
);
  logic                        valid;
  logic                        ready;
  logic [lgs_pkg::CfgIdxW-1:0] index;
  logic [DataW-1:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/life_generation_stencil.sv
// Streaming Game of Life (B3/S23) stencil: cells of one generation enter in raster
// order, one bit per beat, and each next-generation cell leaves as soon as its 3x3
// neighborhood is complete, with its row, column and an end-of-generation flag on the
// last cell. An input beat is taken every cycle as long as each beat yields at most one
// result and the result side takes one beat per cycle; a beat that completes several
// results (the end of a row, and the whole last row; up to four) holds the input back
// while the result register drains them one beat per cycle. A beat that completes a
// result passes stage 1 (line buffer read), then the window update into the result
// register, which offers it; the beat waits in stage 1 while earlier results drain.
// Writing either dimension register restarts the generation at cell (0, 0); the
// configuration port is always ready and should be written only while the block
// is idle.
module life_generation_stencil #(
  parameter int unsigned MAX_ROWS = lgs_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = lgs_pkg::MaxColsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lgs_cell_if.sink     cell_i,
  lgs_result_if.source result_o,
  lgs_cfg_if.sink      cfg_i
);

  localparam int unsigned RowW     = $clog2(MAX_ROWS);
  localparam int unsigned ColW     = $clog2(MAX_COLS);
  localparam int unsigned RowsCfgW = $clog2(MAX_ROWS + 1);
  localparam int unsigned ColsCfgW = $clog2(MAX_COLS + 1);
  localparam int unsigned WinCols  = lgs_pkg::WinCols;

  // Configuration registers and effective grid size.
  logic [RowsCfgW-1:0] active_rows_q;
  logic [ColsCfgW-1:0] active_cols_q;
  logic [RowsCfgW-1:0] rows_eff;
  logic [ColsCfgW-1:0] cols_eff;
  logic [RowsCfgW-1:0] row_last;
  logic [ColsCfgW-1:0] col_last;
  logic                cfg_fire;
  logic                restart;

  // Raster position of the next input beat.
  logic [RowW-1:0] row_cnt_q, row_cnt_d;
  logic [ColW-1:0] col_cnt_q, col_cnt_d;

  // Stage 1: accepted cell while the line buffers are read.
  logic            s1_v_q, s1_v_d;
  logic            s1_alive_q;
  logic [RowW-1:0] s1_row_q;
  logic [ColW-1:0] s1_col_q;
  logic            up_bit;
  logic            pv_bit;
  logic            in_fire;
  logic            s1_adv;

  // Result register: up to four pending results of one cell.
  logic [3:0]      pend_q, pend_d;
  logic [3:0]      pend_left;
  logic [3:0]      pend_first;
  logic [3:0]      res_alive_q;
  logic [3:0]      res_mask;
  logic [3:0]      res_alive;
  logic [RowW-1:0] em_row_q;
  logic [ColW-1:0] em_col_q;
  logic            out_fire;
  logic            em_free;

  // Window chain.
  lgs_pkg::col_bits_t new_col;
  lgs_pkg::col_bits_t win_col [WinCols];
  lgs_pkg::col_bits_t win_feed [WinCols];
  lgs_pkg::col_bits_t left_w, mid_w, right_w, top_mask;

  logic row_is_first, row_is_one, col_is_zero, col_is_one, col_is_last, row_is_last;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  always_comb begin
    restart = 1'b0;
    case (cfg_i.index)
      lgs_pkg::CfgActiveRows, lgs_pkg::CfgActiveCols: restart = cfg_fire;
      default:                                        restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_rows_q <= RowsCfgW'(lgs_pkg::RowsResetVal);
      active_cols_q <= ColsCfgW'(lgs_pkg::ColsResetVal);
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        lgs_pkg::CfgActiveRows: active_rows_q <= cfg_i.data[RowsCfgW-1:0];
        lgs_pkg::CfgActiveCols: active_cols_q <= cfg_i.data[ColsCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (active_rows_q < RowsCfgW'(lgs_pkg::MinDim)) begin
      rows_eff = RowsCfgW'(lgs_pkg::MinDim);
    end else if (active_rows_q > RowsCfgW'(MAX_ROWS)) begin
      rows_eff = RowsCfgW'(MAX_ROWS);
    end else begin
      rows_eff = active_rows_q;
    end
    if (active_cols_q < ColsCfgW'(lgs_pkg::MinDim)) begin
      cols_eff = ColsCfgW'(lgs_pkg::MinDim);
    end else if (active_cols_q > ColsCfgW'(MAX_COLS)) begin
      cols_eff = ColsCfgW'(MAX_COLS);
    end else begin
      cols_eff = active_cols_q;
    end
  end

  assign row_last = rows_eff - 1'b1;
  assign col_last = cols_eff - 1'b1;

  // ---------------------------------------------------------------------------
  // Input side and raster counters
  // ---------------------------------------------------------------------------
  assign cell_i.ready = !s1_v_q || s1_adv;
  assign in_fire      = cell_i.valid && cell_i.ready;

  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (restart) begin
      row_cnt_d = '0;
      col_cnt_d = '0;
    end else if (in_fire) begin
      if (ColsCfgW'(col_cnt_q) == col_last) begin
        col_cnt_d = '0;
        if (RowsCfgW'(row_cnt_q) == row_last) begin
          row_cnt_d = '0;
        end else begin
          row_cnt_d = RowW'(row_cnt_q + 1'b1);
        end
      end else begin
        col_cnt_d = ColW'(col_cnt_q + 1'b1);
      end
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_fire) begin
      s1_v_d = 1'b1;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      s1_v_q    <= 1'b0;
    end else begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      s1_v_q    <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_alive_q <= cell_i.cell_alive;
      s1_row_q   <= row_cnt_q;
      s1_col_q   <= col_cnt_q;
    end
  end

  // The buffers are written when the cell leaves stage 1; the next read of the
  // same column belongs to a cell at least two beats later.
  lgs_line_buf #(
    .Depth (MAX_COLS)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rd_en_i    (in_fire),
    .rd_addr_i  (col_cnt_q),
    .wr_en_i    (s1_adv),
    .wr_addr_i  (s1_col_q),
    .wr_above_i (pv_bit),
    .wr_prev_i  (s1_alive_q),
    .rd_above_o (up_bit),
    .rd_prev_o  (pv_bit)
  );

  // ---------------------------------------------------------------------------
  // Window chain: the newest column enters at the right and moves one cell left
  // on every advancing cell.
  // ---------------------------------------------------------------------------
  assign new_col = {s1_alive_q, pv_bit, up_bit};

  for (genvar k = 0; k < WinCols; k++) begin : g_win
    if (k == WinCols - 1) begin : g_head
      assign win_feed[k] = new_col;
    end else begin : g_link
      assign win_feed[k] = win_col[k+1];
    end
    lgs_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (restart),
      .shift_i (s1_adv),
      .col_i   (win_feed[k]),
      .col_o   (win_col[k])
    );
  end

  // Window as it stands after this cell shifts in.
  assign left_w  = win_col[0];
  assign mid_w   = win_col[1];
  assign right_w = new_col;

  assign row_is_first = (s1_row_q == '0);
  assign row_is_one   = (s1_row_q == RowW'(1));
  assign col_is_zero  = (s1_col_q == '0);
  assign col_is_one   = (s1_col_q == ColW'(1));
  assign col_is_last  = (ColsCfgW'(s1_col_q) == col_last);
  assign row_is_last  = (RowsCfgW'(s1_row_q) == row_last);

  // On the second row the oldest window row lies above the grid.
  assign top_mask = row_is_one ? 3'b110 : 3'b111;

  always_comb begin
    res_mask[0]  = !row_is_first && !col_is_zero;
    res_mask[1]  = !row_is_first && col_is_last;
    res_mask[2]  = row_is_last && !col_is_zero;
    res_mask[3]  = row_is_last && col_is_last;
    res_alive[0] = lgs_pkg::life_rule(col_is_one ? 3'b000 : (left_w & top_mask),
                                      mid_w & top_mask, right_w & top_mask, 1'b1);
    res_alive[1] = lgs_pkg::life_rule(mid_w & top_mask, right_w & top_mask, 3'b000, 1'b1);
    res_alive[2] = lgs_pkg::life_rule(col_is_one ? 3'b000 : left_w, mid_w, right_w, 1'b0);
    res_alive[3] = lgs_pkg::life_rule(mid_w, right_w, 3'b000, 1'b0);
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  assign pend_first = pend_q & (~pend_q + 4'd1);
  assign out_fire   = result_o.valid && result_o.ready;
  assign pend_left  = out_fire ? (pend_q & ~pend_first) : pend_q;
  assign em_free    = (pend_left == 4'd0);
  assign s1_adv     = s1_v_q && em_free;
  assign pend_d     = s1_adv ? res_mask : pend_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_alive_q <= res_alive;
      em_row_q    <= s1_row_q;
      em_col_q    <= s1_col_q;
    end
  end

  // The first two results lie one row up, the even ones one column left.
  assign result_o.valid      = (pend_q != 4'd0);
  assign result_o.out_row    = (pend_first[0] || pend_first[1]) ?
                               RowW'(em_row_q - 1'b1) : em_row_q;
  assign result_o.out_col    = (pend_first[0] || pend_first[2]) ?
                               ColW'(em_col_q - 1'b1) : em_col_q;
  assign result_o.next_alive = |(pend_first & res_alive_q);
  assign result_o.gen_done   = pend_first[3];

endmodule

>>> rtl/lgs_line_buf.sv
module lgs_line_buf #(
  parameter int unsigned Depth = lgs_pkg::MaxColsDef
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic                     wr_above_i,
  input  logic                     wr_prev_i,
  output logic                     rd_above_o,
  output logic                     rd_prev_o
);

  // Two rows back and one row back, read and written at the same column.
  logic above_mem [Depth];
  logic prev_mem  [Depth];
  logic rd_above_q;
  logic rd_prev_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      above_mem[wr_addr_i] <= wr_above_i;
      prev_mem[wr_addr_i]  <= wr_prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_above_q <= above_mem[rd_addr_i];
      rd_prev_q  <= prev_mem[rd_addr_i];
    end
  end

  assign rd_above_o = rd_above_q;
  assign rd_prev_o  = rd_prev_q;

endmodule

>>> rtl/lgs_win_cell.sv
module lgs_win_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               shift_i,
  input  lgs_pkg::col_bits_t col_i,
  output lgs_pkg::col_bits_t col_o
);

  lgs_pkg::col_bits_t col_q;
  lgs_pkg::col_bits_t col_d;

  always_comb begin
    col_d = col_q;
    if (clr_i) begin
      col_d = '0;
    end else if (shift_i) begin
      col_d = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

>>> rtl/lgs_checker.sv
module lgs_checker #(
  parameter int unsigned MAX_ROWS = lgs_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = lgs_pkg::MaxColsDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [$clog2(MAX_ROWS)-1:0] out_row_i,
  input logic [$clog2(MAX_COLS)-1:0] out_col_i,
  input logic                        gen_done_i,
  input logic                        cfg_ready_i
);

  logic out_fire;
  logic gen_start_q;

  assign out_fire = out_valid_i && out_ready_i;

  // Set when the next result beat must be the first cell of a generation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_start_q <= 1'b1;
    end else if (out_fire) begin
      gen_start_q <= gen_done_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  a_done_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && gen_done_i |-> (out_row_i != '0) && (out_col_i != '0))
    else $error("end of generation flagged away from the last corner");

  a_gen_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && gen_start_q |-> (out_row_i == '0) && (out_col_i == '0))
    else $error("generation does not start at cell (0, 0)");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind life_generation_stencil lgs_checker #(
  .MAX_ROWS (MAX_ROWS),
  .MAX_COLS (MAX_COLS)
) u_lgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_row_i   (result_o.out_row),
  .out_col_i   (result_o.out_col),
  .gen_done_i  (result_o.gen_done),
  .cfg_ready_i (cfg_i.ready)
);
